// ===== hw/rtl/sprc_pkg.sv =====
// shared types and constants of the shortest path reach counter
`timescale 1ns / 1ps
`default_nettype none

package sprc_pkg;

    localparam int NODE_W          = 7;
    localparam int DIST_W          = 22;
    localparam int EDGE_W_W        = 16;
    localparam int COUNT_W         = 7;
    localparam int CFG_IDX_W       = 1;
    localparam int DEF_MAX_NODES   = 64;
    localparam int DEF_WEIGHT_BITS = 16;
    localparam int NODE_RESET      = 64;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEL,
        MODE_RELAX,
        MODE_COUNT
    } t_scan_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD_RD,
        ST_LOAD_WR_AB,
        ST_LOAD_WR_BA,
        ST_INIT,
        ST_SEL,
        ST_SEL_END,
        ST_SEL_CHK,
        ST_RELAX,
        ST_RELAX_END,
        ST_COUNT,
        ST_COUNT_END,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       ld_read;
        logic       ld_wr_ab;
        logic       ld_wr_ba;
        logic       init;
        logic       issue;
        t_scan_mode mode;
        logic       settle;
        logic       emit;
        logic       clr_write;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic idx_last;
        logic found;
        logic out_free;
        logic clr_last;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/sprc_ctrl.sv =====
// controller state machine of the shortest path reach counter
`timescale 1ns / 1ps
`default_nettype none

module sprc_ctrl
    import sprc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_LOAD_RD;
            end
            ST_LOAD_RD:    n_state = ST_LOAD_WR_AB;
            ST_LOAD_WR_AB: n_state = ST_LOAD_WR_BA;
            ST_LOAD_WR_BA: begin
                n_state = i_status.last ? ST_INIT : ST_IDLE;
            end
            ST_INIT:       n_state = ST_SEL;
            ST_SEL: begin
                if (i_status.idx_last) n_state = ST_SEL_END;
            end
            ST_SEL_END:    n_state = ST_SEL_CHK;
            ST_SEL_CHK: begin
                n_state = i_status.found ? ST_RELAX : ST_COUNT;
            end
            ST_RELAX: begin
                if (i_status.idx_last) n_state = ST_RELAX_END;
            end
            ST_RELAX_END:  n_state = ST_SEL;
            ST_COUNT: begin
                if (i_status.idx_last) n_state = ST_COUNT_END;
            end
            ST_COUNT_END:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) n_state = ST_CLEAR;
            end
            default:       n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mode = MODE_SEL;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_CLEAR:      o_cmd.clr_write = 1'b1;
            ST_LOAD_RD:    o_cmd.ld_read   = 1'b1;
            ST_LOAD_WR_AB: o_cmd.ld_wr_ab  = 1'b1;
            ST_LOAD_WR_BA: o_cmd.ld_wr_ba  = 1'b1;
            ST_INIT:       o_cmd.init      = 1'b1;
            ST_SEL: begin
                o_cmd.issue = 1'b1;
                o_cmd.mode  = MODE_SEL;
            end
            ST_SEL_CHK:    o_cmd.settle = i_status.found;
            ST_RELAX: begin
                o_cmd.issue = 1'b1;
                o_cmd.mode  = MODE_RELAX;
            end
            ST_COUNT: begin
                o_cmd.issue = 1'b1;
                o_cmd.mode  = MODE_COUNT;
            end
            ST_EMIT:       o_cmd.emit = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // a search only starts from the final edge of a job
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD_WR_BA && n_state == ST_INIT) |-> i_status.last)
        else $error("search started without a final edge");

    // the clear sweep always finishes before the next edge is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && !i_status.clr_last) |=> !o_in_ready)
        else $error("edge taken during clear sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/sprc_datapath.sv =====
// weight and distance memories, scan pipeline and result register
`timescale 1ns / 1ps
`default_nettype none

module sprc_datapath
    import sprc_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIST_W-1:0]    i_cfg_wdata,
    input  wire logic [NODE_W-1:0]    i_endpoint_a,
    input  wire logic [NODE_W-1:0]    i_endpoint_b,
    input  wire logic [EDGE_W_W-1:0]  i_edge_weight,
    input  wire logic                 i_last_edge,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COUNT_W-1:0]        o_reachable_count
);

    localparam int IDX_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > NODE_W) ? CNT_W : NODE_W;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int WS_W   = (WEIGHT_BITS < EDGE_W_W) ? WEIGHT_BITS : EDGE_W_W;
    localparam int WM_W   = WS_W + 1;
    localparam int DEPTH  = 1 << ADDR_W;

    // configuration
    logic [NODE_W-1:0] r_node_count;
    logic [DIST_W-1:0] r_dist_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_W'(NODE_RESET);
            r_dist_limit <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NODE_COUNT:     r_node_count <= i_cfg_wdata[NODE_W-1:0];
                CFG_DISTANCE_LIMIT: r_dist_limit <= i_cfg_wdata;
                default: begin
                    r_node_count <= r_node_count;
                end
            endcase
        end
    end

    // edge latch and range check
    logic [CMP_W-1:0] nc_ext;
    logic [CMP_W-1:0] load_limit;
    logic [CMP_W-1:0] active_nodes;
    logic             in_range;

    assign nc_ext     = CMP_W'(r_node_count);
    assign load_limit = (nc_ext > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : nc_ext;
    assign active_nodes = (nc_ext == '0) ? CMP_W'(1) : load_limit;
    assign in_range   = (i_endpoint_a != '0) && (i_endpoint_b != '0)
                     && (CMP_W'(i_endpoint_a) <= load_limit)
                     && (CMP_W'(i_endpoint_b) <= load_limit);

    logic [IDX_W-1:0] r_a_idx;
    logic [IDX_W-1:0] r_b_idx;
    logic [WS_W-1:0]  r_weight;
    logic             r_in_range;
    logic             r_last;
    logic [CNT_W-1:0] r_nodes;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a_idx    <= IDX_W'(i_endpoint_a - NODE_W'(1));
            r_b_idx    <= IDX_W'(i_endpoint_b - NODE_W'(1));
            r_weight   <= WS_W'(i_edge_weight);
            r_in_range <= in_range;
            r_last     <= i_last_edge;
            r_nodes    <= CNT_W'(active_nodes);
        end
    end

    // scan index and clear sweep address
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              idx_last;

    assign idx_last = (CNT_W'(r_idx) == r_nodes - CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.issue) r_idx <= idx_last ? '0 : r_idx + IDX_W'(1);
            if (i_cmd.clr_write) r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // weight matrix: valid bit above the weight
    logic [WM_W-1:0]   weight_mem [DEPTH];
    logic [WM_W-1:0]   r_w_rd;
    logic [IDX_W-1:0]  r_pick;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [WM_W-1:0]   w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic              keep;

    assign keep    = r_in_range && (!r_w_rd[WS_W] || r_weight < r_w_rd[WS_W-1:0]);
    assign w_we    = i_cmd.clr_write || ((i_cmd.ld_wr_ab || i_cmd.ld_wr_ba) && keep);
    assign w_waddr = i_cmd.clr_write ? r_clr_addr
                   : (i_cmd.ld_wr_ab ? {r_a_idx, r_b_idx} : {r_b_idx, r_a_idx});
    assign w_wdata = i_cmd.clr_write ? '0 : {1'b1, r_weight};
    assign w_re    = i_cmd.ld_read || (i_cmd.issue && i_cmd.mode == MODE_RELAX);
    assign w_raddr = i_cmd.ld_read ? {r_a_idx, r_b_idx} : {r_pick, r_idx};

    always_ff @(posedge i_clk) begin
        if (w_we) weight_mem[w_waddr] <= w_wdata;
        if (w_re) r_w_rd <= weight_mem[w_raddr];
    end

    // distance store, valid through the reached bits
    logic [DIST_W-1:0]    dist_mem [MAX_NODES];
    logic [DIST_W-1:0]    r_d_rd;
    logic                 d_we;
    logic [IDX_W-1:0]     d_waddr;
    logic [DIST_W-1:0]    d_wdata;

    // scan stage, working on the read data in the cycle after the read
    logic             r_p_vld;
    t_scan_mode       r_p_mode;
    logic [IDX_W-1:0] r_p_idx;
    logic [MAX_NODES-1:0] r_reached;
    logic [MAX_NODES-1:0] r_settled;
    logic [DIST_W-1:0] r_best;
    logic              r_found;
    logic [CNT_W-1:0]  r_count;

    logic              first;
    logic              p_reached;
    logic              p_settled;
    logic              sel_take;
    logic              found_base;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] cand_d;
    logic              relax_upd;
    logic              count_hit;

    assign first      = (r_p_idx == '0);
    assign p_reached  = r_reached[r_p_idx];
    assign p_settled  = r_settled[r_p_idx];
    assign found_base = first ? 1'b0 : r_found;
    assign sel_take   = r_p_vld && (r_p_mode == MODE_SEL) && p_reached && !p_settled
                     && (!found_base || r_d_rd < r_best);
    assign sum        = (DIST_W + 1)'(r_best) + (DIST_W + 1)'(r_w_rd[WS_W-1:0]);
    assign cand_d     = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign relax_upd  = r_p_vld && (r_p_mode == MODE_RELAX) && r_w_rd[WS_W] && !p_settled
                     && (!p_reached || cand_d < r_d_rd);
    assign count_hit  = p_reached && (r_d_rd <= r_dist_limit);

    assign d_we    = i_cmd.init || relax_upd;
    assign d_waddr = i_cmd.init ? '0 : r_p_idx;
    assign d_wdata = i_cmd.init ? '0 : cand_d;

    always_ff @(posedge i_clk) begin
        if (d_we) dist_mem[d_waddr] <= d_wdata;
        r_d_rd <= dist_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld   <= 1'b0;
            r_reached <= '0;
            r_settled <= '0;
            r_found   <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.issue;
            if (r_p_vld && r_p_mode == MODE_SEL) r_found <= found_base || sel_take;
            if (i_cmd.emit) begin
                r_reached <= '0;
                r_settled <= '0;
            end else begin
                if (i_cmd.init) r_reached[0] <= 1'b1;
                if (relax_upd) r_reached[r_p_idx] <= 1'b1;
                if (i_cmd.settle) r_settled[r_pick] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_p_mode <= i_cmd.mode;
            r_p_idx  <= r_idx;
        end
        if (sel_take) begin
            r_best <= r_d_rd;
            r_pick <= r_p_idx;
        end
        if (r_p_vld && r_p_mode == MODE_COUNT) begin
            r_count <= (first ? CNT_W'(0) : r_count) + CNT_W'(count_hit);
        end
    end

    // result register
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out_count <= COUNT_W'(r_count);
    end

    assign o_out_valid       = r_out_valid;
    assign o_reachable_count = r_out_count;

    assign o_status.last     = r_last;
    assign o_status.idx_last = idx_last;
    assign o_status.found    = r_found;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.clr_last = (r_clr_addr == '1);

    // a pending result is never overwritten
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // relaxation never lowers a settled distance
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        relax_upd |-> !r_settled[r_p_idx])
        else $error("settled node updated");

    // only a found node is settled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.settle |-> (r_found && r_reached[r_pick]))
        else $error("settled a node that was never picked");

    // the node at distance zero is always reached once a search has begun
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init |=> r_reached[0])
        else $error("source node not reached");

endmodule

`default_nettype wire

// ===== hw/rtl/shortest_path_reach_count.sv =====
// top level of the shortest path reach counter
`timescale 1ns / 1ps
`default_nettype none

// Edges arrive one per transfer with 1-based endpoints and are stored both
// ways in a weight matrix memory, a parallel edge keeping the smaller weight
// and an edge with an endpoint of 0 or above node_count (capped at
// MAX_NODES) being dropped. Each edge passes through idle, a read of the old
// entry and one write per direction through the single write port of the
// matrix before the next edge is taken. The edge marked last starts a search
// from node 1: every round scans the n active nodes for the smallest
// unsettled distance and then relaxes the picked node's row, each scan
// reading the distance memory one entry per cycle. A counting scan over the
// n nodes and the load of the result register follow; the result transfer
// can then wait while the matrix is swept clear, one entry a cycle, over all
// 2**(2*ceil(log2 MAX_NODES)) entries (4096 at 64 nodes). The same clear
// sweep runs after reset, and no edge is taken until it is done;
// configuration writes are taken at any time but belong between jobs.

module shortest_path_reach_count
    import sprc_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIST_W-1:0]    i_cfg_wdata,
    // edge input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [NODE_W-1:0]    i_endpoint_a,
    input  wire logic [NODE_W-1:0]    i_endpoint_b,
    input  wire logic [EDGE_W_W-1:0]  i_edge_weight,
    input  wire logic                 i_last_edge,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [COUNT_W-1:0]        o_reachable_count
);

    t_cmd    cmd;
    t_status status;

    // sequencing of load, search, count and clear
    sprc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // memories, scan pipeline and result register
    sprc_datapath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_endpoint_a      (i_endpoint_a),
        .i_endpoint_b      (i_endpoint_b),
        .i_edge_weight     (i_edge_weight),
        .i_last_edge       (i_last_edge),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_reachable_count (o_reachable_count)
    );

endmodule

`default_nettype wire
